/* hw/rtl/mgad_pkg.sv */
// Shared types and constants for the multibyte glyph address decoder.
package mgad_pkg;

  typedef enum logic [1:0] {
    LANG_HALF = 2'd0,
    LANG_SJIS = 2'd1,
    LANG_EUC  = 2'd2,
    LANG_GB   = 2'd3
  } lang_t;

  localparam logic signed [23:0] NATIONAL_BASE = 24'sd4096;  // 256 glyphs * 16 bytes
  localparam logic signed [17:0] ROW_CELLS     = 18'sd94;
  localparam logic [1:0]         STRIDE_NORMAL = 2'd1;
  localparam logic [1:0]         STRIDE_INTERL = 2'd2;
  localparam int                 QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic        new_string;
    logic [11:0] start_x;
  } chr_t;

  typedef struct packed {
    logic               font_table;
    logic signed [23:0] glyph_offset;
    logic signed [15:0] glyph_x;
    logic [1:0]         row_stride;
    logic               last;
  } cmd_t;

  // Classified character handed from the front end to the back end.
  typedef struct packed {
    logic               is_double;
    logic               font_table;
    logic               interleaved;
    logic [11:0]        single_offset;
    logic signed [9:0]  row_k;
    logic signed [9:0]  cell_t;
    logic [15:0]        xpos;
  } job_t;

endpackage

/* hw/rtl/multibyte_glyph_address_decoder.sv */
// Top level of the multibyte glyph address decoder.
// Text bytes go in through a queue-style port (push/full) and draw commands come out through
// another (empty/pop). The front end accepts one byte every cycle while its two-entry job queue
// has room; lead bytes are held internally and produce nothing. The back end issues one command
// per cycle while its output register is free (empty or popped); a single-byte character yields
// one command and a double-byte trail yields two (left half at x-8, then right half at x). A byte
// passes through the job queue, the back end's work register and the command register before
// its first command is shown.
// lang_mode is written over cfg_valid/cfg_data (always ready) and should only change while idle.
module multibyte_glyph_address_decoder (
  input  logic           clk,
  input  logic           rst,
  input  mgad_pkg::chr_t chr,
  input  logic           push,
  output logic           full,
  output mgad_pkg::cmd_t cmd,
  output logic           empty,
  input  logic           pop,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_data
);
  import mgad_pkg::*;

  logic q_wr;
  logic q_rd;
  logic q_full;
  logic q_empty;
  job_t q_wr_job;
  job_t q_rd_job;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  mgad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chr       (chr),
    .push      (push),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_job     (q_wr_job),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

  mgad_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_job (q_wr_job),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_job (q_rd_job),
    .empty  (q_empty)
  );

  mgad_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (q_rd_job),
    .q_rd    (q_rd),
    .cmd     (cmd),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

/* hw/rtl/mgad_queue.sv */
// Two-entry job queue between the front and back ends.
module mgad_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  mgad_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output mgad_pkg::job_t rd_job,
  output logic          empty
);
  import mgad_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  job_t              entries [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;

  assign full   = (count == (PtrW + 1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/mgad_front.sv */
// Front end: language mode, lead byte, x cursor and character classification.
module mgad_front (
  input  logic           clk,
  input  logic           rst,
  input  mgad_pkg::chr_t chr,
  input  logic           push,
  input  logic           q_full,
  output logic           q_wr,
  output mgad_pkg::job_t q_job,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_data
);
  import mgad_pkg::*;

  lang_t              lang_mode;
  logic [7:0]         pending_lead;
  logic [7:0]         pending_lead_next;
  logic [15:0]        x_cursor;
  logic [15:0]        x_cur;
  logic               accept;
  logic               emit;
  logic [7:0]         b;
  logic [7:0]         lead;
  logic signed [11:0] b_s;
  logic signed [11:0] lead_s;
  logic signed [11:0] k12;
  logic signed [11:0] t12;

  assign accept = push && !q_full;
  assign b      = chr.code_byte;
  assign lead   = pending_lead;
  assign b_s    = $signed({4'b0, b});
  assign lead_s = $signed({4'b0, lead});
  assign x_cur  = chr.new_string ? {4'b0, chr.start_x} : x_cursor;

  always_comb begin
    pending_lead_next   = pending_lead;
    emit                = 1'b0;
    k12                 = '0;
    t12                 = '0;
    q_job.is_double     = 1'b0;
    q_job.font_table    = 1'b1;
    q_job.interleaved   = 1'b0;
    q_job.single_offset = {b, 4'b0};
    q_job.xpos          = x_cur;
    unique case (lang_mode)
      LANG_HALF: begin
        // any held lead is left alone in this mode
        emit             = 1'b1;
        q_job.font_table = 1'b0;
      end
      LANG_SJIS: begin
        if (lead == 8'h00) begin
          if ((b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc)) begin
            pending_lead_next = b;
          end else begin
            emit = 1'b1;
          end
        end else begin
          if (lead >= 8'h81 && lead <= 8'h9f) begin
            k12 = (lead_s - 12'sh081) <<< 1;
          end else begin
            k12 = ((lead_s - 12'sh0e0) <<< 1) + 12'sd62;
          end
          if (b >= 8'h40 && b <= 8'h7e) begin
            t12 = b_s - 12'sh040;
          end else if (b >= 8'h80 && b <= 8'h9e) begin
            t12 = b_s - 12'sh080 + 12'sd63;
          end else begin
            t12 = b_s - 12'sh09f;
            k12 = k12 + 12'sd1;
          end
          pending_lead_next = 8'h00;
          emit              = 1'b1;
          q_job.is_double   = 1'b1;
        end
      end
      LANG_EUC: begin
        if (lead == 8'h00) begin
          if (b >= 8'h81 && b <= 8'hfe) begin
            pending_lead_next = b;
          end else begin
            emit = 1'b1;
          end
        end else begin
          k12               = lead_s - 12'sh0a1;
          t12               = b_s - 12'sh0a1;
          pending_lead_next = 8'h00;
          emit              = 1'b1;
          q_job.is_double   = 1'b1;
        end
      end
      LANG_GB: begin
        if (lead == 8'h00) begin
          if (b >= 8'ha0) begin
            pending_lead_next = b;
          end else begin
            emit             = 1'b1;
            q_job.font_table = 1'b0;
          end
        end else begin
          // row and cell are one-based here, so fold the -1 in now
          k12               = lead_s - 12'sh0a1;
          t12               = b_s - 12'sh0a1;
          pending_lead_next = 8'h00;
          emit              = 1'b1;
          q_job.is_double   = 1'b1;
          q_job.interleaved = 1'b1;
        end
      end
      default: begin
        emit = 1'b1;
      end
    endcase
    q_job.row_k  = k12[9:0];
    q_job.cell_t = t12[9:0];
  end

  assign q_wr = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lang_mode    <= LANG_HALF;
      pending_lead <= '0;
      x_cursor     <= '0;
    end else begin
      if (cfg_valid) begin
        lang_mode <= lang_t'(cfg_data);
      end
      if (accept) begin
        pending_lead <= pending_lead_next;
        x_cursor     <= x_cur + 16'd8;
      end
    end
  end

endmodule

/* hw/rtl/mgad_back.sv */
// Back end: offset arithmetic and one draw command per cycle into the result register while it is free.
module mgad_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mgad_pkg::job_t q_job,
  output logic           q_rd,
  output mgad_pkg::cmd_t cmd,
  output logic           empty,
  input  logic           pop
);
  import mgad_pkg::*;

  job_t               w_job;
  logic               w_valid;
  logic               w_half;
  logic               out_valid;
  cmd_t               cmd_next;
  logic               out_free;
  logic               fire;
  logic               w_done;
  logic               w_load;
  logic signed [17:0] cell_index;
  logic signed [23:0] base;

  assign out_free = !out_valid || pop;
  assign fire     = w_valid && out_free;
  assign w_done   = fire && (!w_job.is_double || w_half);
  assign w_load   = !q_empty && (!w_valid || w_done);
  assign q_rd     = w_load;
  assign empty    = !out_valid;

  assign cell_index = $signed({{8{w_job.row_k[9]}}, w_job.row_k}) * ROW_CELLS
                    + $signed({{8{w_job.cell_t[9]}}, w_job.cell_t});
  assign base = ($signed({{6{cell_index[17]}}, cell_index}) <<< 5)
              + (w_job.interleaved ? 24'sd0 : NATIONAL_BASE);

  always_comb begin
    cmd_next.font_table = w_job.font_table;
    cmd_next.row_stride = w_job.interleaved ? STRIDE_INTERL : STRIDE_NORMAL;
    if (!w_job.is_double) begin
      cmd_next.glyph_offset = $signed({12'b0, w_job.single_offset});
      cmd_next.glyph_x      = $signed(w_job.xpos);
      cmd_next.last         = 1'b1;
    end else if (!w_half) begin
      cmd_next.glyph_offset = base;
      cmd_next.glyph_x      = $signed(w_job.xpos - 16'd8);
      cmd_next.last         = 1'b0;
    end else begin
      // right half: next column in interleaved fonts, next 16 bytes otherwise
      cmd_next.glyph_offset = base + (w_job.interleaved ? 24'sd1 : 24'sd16);
      cmd_next.glyph_x      = $signed(w_job.xpos);
      cmd_next.last         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (w_load) begin
      w_job <= q_job;
    end
    if (fire) begin
      cmd <= cmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid   <= 1'b0;
      w_half    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (w_load) begin
        w_valid <= 1'b1;
        w_half  <= 1'b0;
      end else if (w_done) begin
        w_valid <= 1'b0;
      end else if (fire) begin
        w_half <= 1'b1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/mgad_checker.sv */
// Port-level assertions for the multibyte glyph address decoder, bound to the top level.
module mgad_checker (
  input logic           clk,
  input logic           rst,
  input mgad_pkg::cmd_t cmd,
  input logic           empty,
  input logic           pop
);
  import mgad_pkg::*;

  // nothing is shown straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(cmd)))
    else $error("waiting result changed or vanished");

  // a left half is always followed at once by its right half
  a_pair: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !cmd.last) |=> !empty)
    else $error("right half not ready behind left half");

  a_left_national: assert property (@(posedge clk) disable iff (rst)
    (!empty && !cmd.last) |-> cmd.font_table)
    else $error("left half not from national font");

  a_stride: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((cmd.row_stride == STRIDE_NORMAL) ||
                (cmd.row_stride == STRIDE_INTERL && cmd.font_table)))
    else $error("bad row stride");

endmodule

bind multibyte_glyph_address_decoder mgad_checker u_checker (.*);
